// ===== rtl/core/indexed_insert_remove_list_unit_macros.svh =====
// Assertion macros for the indexed insert/remove list unit.
// Included by the top-level module, which carries the concurrent assertions; no dependencies.
`ifndef INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH
`define INDEXED_INSERT_REMOVE_LIST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define IIRL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iirl assertion failed");
`define IIRL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iirl assertion failed");
`else
`define IIRL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IIRL_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/iirl_pkg.sv =====
// Package for the indexed insert/remove list unit: sizes, codes, types.
// No dependencies; imported by every module of the unit.
package iirl_pkg;

   localparam int CAPACITY   = 256;
   localparam int ITEM_WIDTH = 32;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 9;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FOUND_W  = 8;
   localparam int COUNT_W  = 9;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam int GRP_SIZE = 16;
   localparam int GSEL_W   = $clog2(GRP_SIZE);
   localparam int NUM_GRP  = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GIDX_W   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int PAD_CAP  = NUM_GRP * GRP_SIZE;
   localparam int PAD_W    = GIDX_W + GSEL_W;

   typedef enum logic [KIND_W-1:0] {
      KIND_APPEND     = 3'd0,
      KIND_INSERT     = 3'd1,
      KIND_REPLACE    = 3'd2,
      KIND_REMOVE     = 3'd3,
      KIND_READ       = 3'd4,
      KIND_FIND_FIRST = 3'd5,
      KIND_FIND_LAST  = 3'd6,
      KIND_CLEAR      = 3'd7
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_MISS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESOLVE
   } state_type;

   typedef struct packed {
      logic                  wr;
      logic                  ins;
      logic                  rem;
      logic                  scan;
      logic [CMP_W-1:0]      pos;
      logic [CMP_W-1:0]      count;
      logic [ITEM_WIDTH-1:0] value;
   } cell_ctl_type;

endpackage

// ===== rtl/core/indexed_insert_remove_list_unit.sv =====
// Top level of the indexed insert/remove list unit: control, cell chain,
// result register. Depends on iirl_pkg, iirl_cell, iirl_find and the macros.
//
// Keeps an ordered list of up to CAPACITY items in a chain of cells, one
// item per cell. A transaction passes scan, then resolve; the next can
// enter as its result loads. In scan, cells shift or write in parallel
// for append, insert, replace and remove, and capture their compare lines
// and a per-group read selection; in resolve, the match lines go through
// a two-level priority encoder and the result is loaded into the output
// register. A waiting result does not block the next transaction until
// it would need to be overwritten. Nothing needs clearing after reset.
module indexed_insert_remove_list_unit import iirl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [POS_W-1:0]    req_position,
   input  logic [VALUE_W-1:0]  req_item_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [VALUE_W-1:0]  rsp_read_data,
   output logic [FOUND_W-1:0]  rsp_found_index,
   output logic [COUNT_W-1:0]  rsp_item_count
);

`include "indexed_insert_remove_list_unit_macros.svh"

   state_type             state_ff, state_in;
   kind_type              kind_ff;
   logic [CMP_W-1:0]      pos_ff;
   logic [ITEM_WIDTH-1:0] value_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   status_type            status_ff;

   logic                  accept;
   logic                  load;
   logic                  in_scan;

   status_type            scan_status;
   logic [CNT_W-1:0]      scan_count;
   logic                  scan_wr, scan_ins, scan_rem;
   logic [CMP_W-1:0]      cnt_w;
   cell_ctl_type          ctl;

   logic [ITEM_WIDTH-1:0] cell_data [PAD_CAP];
   logic [ITEM_WIDTH-1:0] cell_rd   [PAD_CAP];
   logic [PAD_CAP-1:0]    match_vec;

   logic [ITEM_WIDTH-1:0] grp_rd_ff [NUM_GRP];
   logic [ITEM_WIDTH-1:0] grp_rd_in [NUM_GRP];
   logic [ITEM_WIDTH-1:0] rd_or;

   logic                  find_hit;
   logic [PAD_W-1:0]      find_idx;
   logic                  is_find;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, res_status;
   logic [VALUE_W-1:0]    rsp_read_data_ff, res_read_data;
   logic [FOUND_W-1:0]    rsp_found_index_ff, res_found_index;
   logic [COUNT_W-1:0]    rsp_item_count_ff;

   assign in_scan = (state_ff == ST_SCAN);
   assign cnt_w   = CMP_W'(count_ff);
   assign is_find = (kind_ff == KIND_FIND_FIRST) || (kind_ff == KIND_FIND_LAST);

   always_comb begin
      scan_status = STAT_OK;
      scan_count  = count_ff;
      scan_wr     = 1'b0;
      scan_ins    = 1'b0;
      scan_rem    = 1'b0;
      case (kind_ff)
         KIND_APPEND: begin
            if (cnt_w >= CMP_W'(CAPACITY)) begin
               scan_status = STAT_FULL;
            end else begin
               scan_wr    = 1'b1;
               scan_count = count_ff + 1'b1;
            end
         end
         KIND_INSERT: begin
            if (pos_ff > cnt_w) begin
               scan_status = STAT_RANGE;
            end else if (cnt_w >= CMP_W'(CAPACITY)) begin
               scan_status = STAT_FULL;
            end else begin
               scan_wr    = 1'b1;
               scan_ins   = 1'b1;
               scan_count = count_ff + 1'b1;
            end
         end
         KIND_REPLACE: begin
            if (pos_ff >= cnt_w) begin
               scan_status = STAT_RANGE;
            end else begin
               scan_wr = 1'b1;
            end
         end
         KIND_REMOVE: begin
            if (pos_ff >= cnt_w) begin
               scan_status = STAT_RANGE;
            end else begin
               scan_rem   = 1'b1;
               scan_count = count_ff - 1'b1;
            end
         end
         KIND_READ: begin
            if (pos_ff >= cnt_w) begin
               scan_status = STAT_RANGE;
            end
         end
         KIND_CLEAR: begin
            scan_count = '0;
         end
         default: begin
            scan_status = STAT_OK;
         end
      endcase
   end

   always_comb begin
      ctl.wr    = in_scan && scan_wr;
      ctl.ins   = in_scan && scan_ins;
      ctl.rem   = in_scan && scan_rem;
      ctl.scan  = in_scan;
      ctl.pos   = (kind_ff == KIND_APPEND) ? cnt_w : pos_ff;
      ctl.count = cnt_w;
      ctl.value = value_ff;
   end

   for (genvar i = 0; i < PAD_CAP; i++) begin : g_cell
      if (i < CAPACITY) begin : g_real
         localparam int L = (i == 0) ? 0 : i - 1;
         localparam int R = (i == CAPACITY - 1) ? i : i + 1;
         iirl_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctl),
            .cell_index (IDX_W'(i)),
            .left_data  (cell_data[L]),
            .right_data (cell_data[R]),
            .cell_data  (cell_data[i]),
            .rd_data    (cell_rd[i]),
            .match      (match_vec[i])
         );
      end else begin : g_pad
         assign cell_data[i] = '0;
         assign cell_rd[i]   = '0;
         assign match_vec[i] = 1'b0;
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_rd_in[g] = '0;
         for (int k = 0; k < GRP_SIZE; k++) begin
            grp_rd_in[g] = grp_rd_in[g] | cell_rd[g*GRP_SIZE + k];
         end
      end
      rd_or = '0;
      for (int g = 0; g < NUM_GRP; g++) begin
         rd_or = rd_or | grp_rd_ff[g];
      end
   end

   iirl_find u_find (
      .match_vec (match_vec),
      .find_last (kind_ff == KIND_FIND_LAST),
      .hit       (find_hit),
      .hit_index (find_idx)
   );

   always_comb begin
      res_status      = status_ff;
      res_read_data   = '0;
      res_found_index = '0;
      if (is_find) begin
         res_status = find_hit ? STAT_OK : STAT_MISS;
         if (find_hit) begin
            res_found_index = FOUND_W'(find_idx);
         end
      end
      if (kind_ff == KIND_READ && status_ff == STAT_OK) begin
         res_read_data = VALUE_W'(rd_or);
      end
   end

   always_comb begin
      state_in     = state_ff;
      load         = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            load = !rsp_valid_ff || !rsp_stall;
            if (load) begin
               req_stall = 1'b0;
               state_in  = req_valid ? ST_SCAN : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      accept       = req_valid && !req_stall;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_scan) begin
            count_ff <= scan_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind_type'(req_kind);
         pos_ff   <= CMP_W'(req_position);
         value_ff <= ITEM_WIDTH'(req_item_value);
      end
      if (in_scan) begin
         status_ff <= scan_status;
         for (int g = 0; g < NUM_GRP; g++) begin
            grp_rd_ff[g] <= grp_rd_in[g];
         end
      end
      if (load) begin
         rsp_status_ff      <= res_status;
         rsp_read_data_ff   <= res_read_data;
         rsp_found_index_ff <= res_found_index;
         rsp_item_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_data   = rsp_read_data_ff;
   assign rsp_found_index = rsp_found_index_ff;
   assign rsp_item_count  = rsp_item_count_ff;

   `IIRL_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))
   `IIRL_ASSERT_NXT(a_accept_scan, clock, reset, accept, state_ff == ST_SCAN)
   `IIRL_ASSERT_NXT(a_scan_resolve, clock, reset, in_scan, state_ff == ST_RESOLVE)
   `IIRL_ASSERT_NXT(a_clear_empty, clock, reset, in_scan && kind_ff == KIND_CLEAR, count_ff == '0)

endmodule

// ===== rtl/core/iirl_cell.sv =====
// One storage cell of the list: holds one item, shifts with its neighbors,
// drives its compare and read-select lines. Depends on iirl_pkg.
module iirl_cell import iirl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctl_type          ctl,
   input  logic [IDX_W-1:0]      cell_index,
   input  logic [ITEM_WIDTH-1:0] left_data,
   input  logic [ITEM_WIDTH-1:0] right_data,
   output logic [ITEM_WIDTH-1:0] cell_data,
   output logic [ITEM_WIDTH-1:0] rd_data,
   output logic                  match
);

   logic [ITEM_WIDTH-1:0] data_ff, data_in;
   logic                  match_ff, match_in;
   logic [CMP_W-1:0]      idx_w;

   assign idx_w = CMP_W'(cell_index);

   always_comb begin
      data_in = data_ff;
      if (ctl.wr && idx_w == ctl.pos) begin
         data_in = ctl.value;
      end else if (ctl.ins && idx_w > ctl.pos) begin
         data_in = left_data;
      end else if (ctl.rem && idx_w >= ctl.pos) begin
         data_in = right_data;
      end
      match_in = ctl.scan ? ((data_ff == ctl.value) && (idx_w < ctl.count)) : match_ff;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign cell_data = data_ff;
   assign rd_data   = (idx_w == ctl.pos) ? data_ff : '0;
   assign match     = match_ff;

endmodule

// ===== rtl/core/iirl_find.sv =====
// Two-level priority encoder over the registered match lines of the cells.
// Finds the lowest or highest hit. Depends on iirl_pkg.
module iirl_find import iirl_pkg::*; (
   input  logic [PAD_CAP-1:0] match_vec,
   input  logic               find_last,
   output logic               hit,
   output logic [PAD_W-1:0]   hit_index
);

   logic [NUM_GRP-1:0] grp_hit;
   logic [GSEL_W-1:0]  grp_pos [NUM_GRP];
   logic [GIDX_W-1:0]  grp_sel;

   function automatic logic [GSEL_W-1:0] pick_sub(input logic [GRP_SIZE-1:0] v,
                                                  input logic last);
      logic [GSEL_W-1:0] res;
      logic              fnd;
      res = '0;
      fnd = 1'b0;
      for (int i = 0; i < GRP_SIZE; i++) begin
         if (v[i] && (last || !fnd)) begin
            res = GSEL_W'(i);
            fnd = 1'b1;
         end
      end
      return res;
   endfunction

   function automatic logic [GIDX_W-1:0] pick_grp(input logic [NUM_GRP-1:0] v,
                                                  input logic last);
      logic [GIDX_W-1:0] res;
      logic              fnd;
      res = '0;
      fnd = 1'b0;
      for (int i = 0; i < NUM_GRP; i++) begin
         if (v[i] && (last || !fnd)) begin
            res = GIDX_W'(i);
            fnd = 1'b1;
         end
      end
      return res;
   endfunction

   always_comb begin
      for (int g = 0; g < NUM_GRP; g++) begin
         grp_hit[g] = |match_vec[g*GRP_SIZE +: GRP_SIZE];
         grp_pos[g] = pick_sub(match_vec[g*GRP_SIZE +: GRP_SIZE], find_last);
      end
      grp_sel   = pick_grp(grp_hit, find_last);
      hit       = |grp_hit;
      hit_index = {grp_sel, grp_pos[grp_sel]};
   end

endmodule

// ===== verif/tb_indexed_insert_remove_list_unit.sv =====
// Testbench for indexed_insert_remove_list_unit: directed table, then random op mixes and
// fill-to-full runs; each response is checked against a behavioral list model or, for
// typed rows, the table's status and count. Depends on iirl_pkg and the unit's RTL.
module tb_indexed_insert_remove_list_unit;
   import iirl_pkg::*;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_ITEMS  = 1100;
   localparam int IDLE_LIMIT    = 5000;
   localparam int HOLD_PERIOD   = 2000;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   read_data;
      logic [FOUND_W-1:0]   found_index;
      logic [COUNT_W-1:0]   item_count;
   } list_result_type;

   typedef struct packed {
      kind_type             kind;
      logic [POS_W-1:0]     pos;
      logic [VALUE_W-1:0]   value;
      logic                 typed;
      status_type           status;
      logic [COUNT_W-1:0]   item_count;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind = '0;
   logic [POS_W-1:0]    req_position = '0;
   logic [VALUE_W-1:0]  req_item_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [VALUE_W-1:0]  rsp_read_data;
   logic [FOUND_W-1:0]  rsp_found_index;
   logic [COUNT_W-1:0]  rsp_item_count;

   logic [ITEM_WIDTH-1:0] list_items [CAPACITY];
   int                    list_len = 0;
   list_result_type       pending_list_results [$];
   logic [VALUE_W-1:0]    value_pool [8];

   int failures = 0;
   int ops_sent = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int recv_cycle = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   dir_row_type dir_rows [DIRECTED_ROWS] = '{
      '{KIND_READ,        9'd0,   32'h0,        1'b1, STAT_RANGE, 9'd0},
      '{KIND_FIND_FIRST,  9'd0,   32'h0,        1'b1, STAT_MISS,  9'd0},
      '{KIND_FIND_LAST,   9'd0,   32'hFFFFFFFF, 1'b1, STAT_MISS,  9'd0},
      '{KIND_REMOVE,      9'd0,   32'h0,        1'b1, STAT_RANGE, 9'd0},
      '{KIND_REPLACE,     9'd0,   32'h1,        1'b1, STAT_RANGE, 9'd0},
      '{KIND_INSERT,      9'd1,   32'h2,        1'b1, STAT_RANGE, 9'd0},
      '{KIND_INSERT,      9'd0,   32'hFFFFFFFF, 1'b1, STAT_OK,    9'd1},
      '{KIND_APPEND,      9'd511, 32'h0,        1'b1, STAT_OK,    9'd2},
      '{KIND_APPEND,      9'd0,   32'hA5A5A5A5, 1'b0, STAT_OK,    9'd0},
      '{KIND_INSERT,      9'd3,   32'h5A5A5A5A, 1'b0, STAT_OK,    9'd0},
      '{KIND_INSERT,      9'd1,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_READ,        9'd0,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_READ,        9'd4,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_FIND_FIRST,  9'd0,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_FIND_LAST,   9'd0,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_REPLACE,     9'd2,   32'h12345678, 1'b0, STAT_OK,    9'd0},
      '{KIND_FIND_LAST,   9'd0,   32'h12345678, 1'b0, STAT_OK,    9'd0},
      '{KIND_FIND_FIRST,  9'd0,   32'hDEADBEEF, 1'b0, STAT_OK,    9'd0},
      '{KIND_REMOVE,      9'd0,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_REMOVE,      9'd3,   32'h0,        1'b0, STAT_OK,    9'd0},
      '{KIND_READ,        9'd511, 32'h0,        1'b1, STAT_RANGE, 9'd3},
      '{KIND_READ,        9'd256, 32'h0,        1'b1, STAT_RANGE, 9'd3},
      '{KIND_CLEAR,       9'd0,   32'h0,        1'b1, STAT_OK,    9'd0},
      '{KIND_FIND_FIRST,  9'd0,   32'h0,        1'b1, STAT_MISS,  9'd0},
      '{KIND_APPEND,      9'd0,   32'h80000001, 1'b1, STAT_OK,    9'd1}
   };

   indexed_insert_remove_list_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_read_data   (rsp_read_data),
      .rsp_found_index (rsp_found_index),
      .rsp_item_count  (rsp_item_count)
   );

   always #5 clock = ~clock;

   function automatic list_result_type apply_list_op(kind_type k, logic [POS_W-1:0] p,
                                                     logic [VALUE_W-1:0] v);
      list_result_type r;
      int pi;
      int i;
      bit hit;
      r = '{STAT_OK, '0, '0, '0};
      pi = int'(p);
      hit = 1'b0;
      case (k)
         KIND_APPEND: begin
            if (list_len >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               list_items[list_len] = v;
               list_len++;
            end
         end
         KIND_INSERT: begin
            if (pi > list_len) begin
               r.status = STAT_RANGE;
            end else if (list_len >= CAPACITY) begin
               r.status = STAT_FULL;
            end else begin
               for (i = list_len; i > pi; i--) list_items[i] = list_items[i-1];
               list_items[pi] = v;
               list_len++;
            end
         end
         KIND_REPLACE: begin
            if (pi >= list_len) r.status = STAT_RANGE;
            else list_items[pi] = v;
         end
         KIND_REMOVE: begin
            if (pi >= list_len) begin
               r.status = STAT_RANGE;
            end else begin
               for (i = pi; i + 1 < list_len; i++) list_items[i] = list_items[i+1];
               list_len--;
            end
         end
         KIND_READ: begin
            if (pi >= list_len) r.status = STAT_RANGE;
            else r.read_data = list_items[pi];
         end
         KIND_FIND_FIRST: begin
            r.status = STAT_MISS;
            for (i = 0; i < list_len && !hit; i++) begin
               if (list_items[i] == v) begin
                  hit = 1'b1;
                  r.status = STAT_OK;
                  r.found_index = i[FOUND_W-1:0];
               end
            end
         end
         KIND_FIND_LAST: begin
            r.status = STAT_MISS;
            for (i = list_len - 1; i >= 0 && !hit; i--) begin
               if (list_items[i] == v) begin
                  hit = 1'b1;
                  r.status = STAT_OK;
                  r.found_index = i[FOUND_W-1:0];
               end
            end
         end
         default: list_len = 0;
      endcase
      r.item_count = list_len[COUNT_W-1:0];
      return r;
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 5) return value_pool[$urandom_range(0, 7)];
      if (sel == 5) return '0;
      if (sel == 6) return '1;
      return $urandom;
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      if ($urandom_range(0, 99) < 85) return POS_W'($urandom_range(0, list_len));
      return POS_W'($urandom_range(0, 511));
   endfunction

   task automatic send_op(input kind_type k, input logic [POS_W-1:0] p,
                          input logic [VALUE_W-1:0] v, input bit typed = 1'b0,
                          input status_type tst = STAT_OK,
                          input logic [COUNT_W-1:0] tcnt = '0);
      list_result_type r;
      req_valid      <= 1'b1;
      req_kind       <= k;
      req_position   <= p;
      req_item_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = apply_list_op(k, p, v);
      if (typed) r = '{tst, '0, '0, tcnt};
      pending_list_results.push_back(r);
      ops_sent++;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic run_mixed(input int n);
      kind_type k;
      repeat (n) begin
         if ($urandom_range(0, 99) < 2) k = KIND_CLEAR;
         else k = kind_type'($urandom_range(0, 6));
         send_op(k, pick_pos(), pick_value());
      end
   endtask

   task automatic run_fill();
      logic [VALUE_W-1:0] uv;
      while (list_len < CAPACITY) begin
         if ($urandom_range(0, 1) == 0) send_op(KIND_APPEND, '0, pick_value());
         else send_op(KIND_INSERT, POS_W'($urandom_range(0, list_len)), pick_value());
      end
      uv = $urandom;
      send_op(KIND_APPEND, '0, uv);
      send_op(KIND_INSERT, POS_W'($urandom_range(0, CAPACITY)), uv);
      send_op(KIND_INSERT, POS_W'($urandom_range(CAPACITY + 1, 511)), uv);
      send_op(KIND_REPLACE, POS_W'(CAPACITY - 1), uv);
      send_op(KIND_FIND_FIRST, '0, uv);
      send_op(KIND_FIND_LAST, '0, uv);
      send_op(KIND_READ, POS_W'(CAPACITY - 1), '0);
      run_mixed(8);
   endtask

   initial begin
      int ph;
      int sel;
      foreach (value_pool[j]) value_pool[j] = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 83 : 0;
         recv_idle_pct <= (ph == 0) ? 83 : (ph == 1) ? 20 : 0;
         if (ph == 0) begin
            foreach (dir_rows[j])
               send_op(dir_rows[j].kind, dir_rows[j].pos, dir_rows[j].value,
                       dir_rows[j].typed, dir_rows[j].status, dir_rows[j].item_count);
         end
         if (ph != 1) run_fill();
         while (ops_sent < DIRECTED_ROWS + (ph + 1) * RANDOM_ITEMS / 3) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
               run_mixed($urandom_range(10, 40));
            end else if (sel < 85) begin
               repeat ($urandom_range(5, 20))
                  send_op(kind_type'($urandom_range(0, 7)), POS_W'($urandom_range(0, 511)),
                          $urandom);
            end else if (sel < 93) begin
               repeat ($urandom_range(3, 20)) send_op(KIND_REMOVE, pick_pos(), '0);
            end else begin
               send_op(KIND_CLEAR, pick_pos(), pick_value());
            end
         end
      end
      req_valid <= 1'b0;
      while (pending_list_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // receiver: random stalls plus a periodic long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         recv_cycle <= 0;
         hold_left  <= 0;
      end else begin
         recv_cycle <= recv_cycle + 1;
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (recv_cycle % HOLD_PERIOD == HOLD_PERIOD - 1) begin
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_list_results.size() == 0) begin
            $error("response transaction with nothing expected");
            failures++;
         end else begin
            want = pending_list_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
               failures++;
            end
            if (rsp_found_index !== want.found_index) begin
               $error("found_index: expected %0d, got %0d", want.found_index,
                      rsp_found_index);
               failures++;
            end
            if (rsp_item_count !== want.item_count) begin
               $error("item_count: expected %0d, got %0d", want.item_count, rsp_item_count);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/iirl_pkg.sv
rtl/core/iirl_cell.sv
rtl/core/iirl_find.sv
rtl/core/indexed_insert_remove_list_unit.sv
verif/tb_indexed_insert_remove_list_unit.sv
